[rtl/vsrbp_pkg.sv]
// Shared types, constants and helper functions of the shape record bit packer.
package vsrbp_pkg;

  localparam int unsigned DefaultQueueDepth = 4;
  localparam int unsigned CfgIndexWidth     = 2;
  localparam int unsigned CountWidth        = 16;
  localparam int unsigned CoordWidth        = 32;
  localparam int unsigned BitsWidth         = 31;
  localparam int unsigned WidthWidth        = 5;
  localparam int unsigned SlotCount         = 7;
  localparam int unsigned CurveWidth        = 17;

  localparam logic [CfgIndexWidth-1:0] CFG_FILL_COUNT = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_LINE_COUNT = 2'd1;

  typedef enum logic [1:0] {
    CMD_STYLE   = 2'd0,
    CMD_EDGE    = 2'd1,
    CMD_CURVE   = 2'd2,
    CMD_UNKNOWN = 2'd3
  } command_t;

  // Field codes and widths that appear in the packed stream.
  localparam logic [4:0] FLAGS_WIDTH      = 5'd6;
  localparam logic [4:0] MOVE_BITS_WIDTH  = 5'd5;
  localparam logic [4:0] EDGE_NBITS_WIDTH = 5'd4;
  localparam logic [4:0] TAG_WIDTH        = 5'd2;
  localparam logic [1:0] EDGE_TAG         = 2'd3;
  localparam logic [1:0] CURVE_TAG        = 2'd2;
  localparam logic [1:0] VERT_TAG         = 2'd1;
  localparam logic [1:0] HORZ_TAG         = 2'd0;
  localparam logic [1:0] GENERAL_TAG      = 2'd1;
  localparam logic [1:0] LINE_TAG_WIDTH   = 2'd2;
  localparam logic [1:0] GENERAL_TAG_WIDTH = 2'd1;
  localparam logic [5:0] MOVE_LIMIT       = 6'd32;
  localparam logic [5:0] EDGE_LIMIT       = 6'd18;
  localparam logic [5:0] MIN_EDGE_WIDTH   = 6'd2;
  localparam logic [4:0] NBITS_BIAS       = 5'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic [5:0]         flags;
    logic signed [31:0] coord_a;
    logic signed [31:0] coord_b;
    logic signed [31:0] coord_c;
    logic signed [31:0] coord_d;
    logic [15:0]        left_fill;
    logic [15:0]        right_fill;
    logic [15:0]        line_style;
  } shape_t;

  typedef struct packed {
    logic [30:0] field_bits;
    logic [4:0]  field_width;
    logic        last;
    logic        error;
  } field_t;

  typedef enum logic [1:0] {
    JOB_STYLE = 2'd0,
    JOB_EDGE  = 2'd1,
    JOB_CURVE = 2'd2,
    JOB_ERROR = 2'd3
  } job_kind_t;

  // One classified record as it waits for the back end.
  typedef struct packed {
    job_kind_t                 kind;
    logic [SlotCount-1:0]      slot_mask;
    logic [5:0]                flags;
    logic [WidthWidth-1:0]     width;
    logic [1:0]                tag_bits;
    logic [1:0]                tag_width;
    logic [BitsWidth-1:0]      a;
    logic [BitsWidth-1:0]      b;
    logic [CurveWidth-1:0]     c;
    logic [CurveWidth-1:0]     d;
    logic [CountWidth-1:0]     left_fill;
    logic [CountWidth-1:0]     right_fill;
    logic [CountWidth-1:0]     line_style;
    logic [WidthWidth-1:0]     fill_width;
    logic [WidthWidth-1:0]     line_width;
  } job_t;

  // Smallest two's complement width that holds the value.
  function automatic logic [5:0] sig_len(input logic [CoordWidth-1:0] u);
    logic [CoordWidth-1:0] v;
    logic [5:0]            n;
    v = u[CoordWidth-1] ? ~u : u;
    n = '0;
    for (int i = 0; i < CoordWidth; i++) begin
      if (v[i]) begin
        n = 6'(i + 1);
      end
    end
    return n + 6'd1;
  endfunction

  // Bit length of an unsigned count.
  function automatic logic [4:0] idx_len(input logic [CountWidth-1:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < CountWidth; i++) begin
      if (v[i]) begin
        n = 5'(i + 1);
      end
    end
    return n;
  endfunction

  function automatic logic [5:0] max6(input logic [5:0] x, input logic [5:0] y);
    return (x > y) ? x : y;
  endfunction

endpackage

[rtl/vsrbp_front.sv]
// Front end: takes records, holds the style counts and classifies each record into a job.
module vsrbp_front #(
  parameter int unsigned QueueDepth = vsrbp_pkg::DefaultQueueDepth,
  localparam int unsigned LevelWidth = $clog2(QueueDepth + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  vsrbp_pkg::shape_t                   shape,
  input  logic                                cfg_valid,
  input  logic [vsrbp_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [vsrbp_pkg::CountWidth-1:0]    cfg_data,
  input  logic [LevelWidth-1:0]               level,
  output logic                                push,
  output vsrbp_pkg::job_t                     push_job
);
  import vsrbp_pkg::*;

  logic                  s1_valid;
  shape_t                s1_shape;
  logic [CountWidth-1:0] fill_count;
  logic [CountWidth-1:0] line_count;

  logic [5:0] len_a, len_b, len_c, len_d, len_ab, len_all, len_edge, len_curve;

  // Every record held in the front stage is guaranteed a queue slot.
  assign busy = ((LevelWidth + 1)'(level) + (LevelWidth + 1)'(s1_valid))
                >= (LevelWidth + 1)'(QueueDepth);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      fill_count <= '0;
      line_count <= '0;
    end else begin
      s1_valid <= start && !busy;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_FILL_COUNT: fill_count <= cfg_data;
          CFG_LINE_COUNT: line_count <= cfg_data;
          default: ;
        endcase
      end
    end
    if (start && !busy) begin
      s1_shape <= shape;
    end
  end

  assign len_a     = sig_len(s1_shape.coord_a);
  assign len_b     = sig_len(s1_shape.coord_b);
  assign len_c     = sig_len(s1_shape.coord_c);
  assign len_d     = sig_len(s1_shape.coord_d);
  assign len_ab    = max6(len_a, len_b);
  assign len_all   = max6(len_ab, max6(len_c, len_d));
  assign len_edge  = max6(len_ab, MIN_EDGE_WIDTH);
  assign len_curve = max6(len_all, MIN_EDGE_WIDTH);

  always_comb begin
    push_job            = '0;
    push_job.flags      = s1_shape.flags;
    push_job.a          = s1_shape.coord_a[BitsWidth-1:0];
    push_job.b          = s1_shape.coord_b[BitsWidth-1:0];
    push_job.c          = s1_shape.coord_c[CurveWidth-1:0];
    push_job.d          = s1_shape.coord_d[CurveWidth-1:0];
    push_job.left_fill  = s1_shape.left_fill;
    push_job.right_fill = s1_shape.right_fill;
    push_job.line_style = s1_shape.line_style;
    push_job.fill_width = idx_len(fill_count);
    push_job.line_width = idx_len(line_count);
    push_job.kind       = JOB_ERROR;
    push_job.slot_mask  = 7'b0000001;
    case (s1_shape.command)
      CMD_STYLE: begin
        if (!(s1_shape.flags[0] && len_ab >= MOVE_LIMIT)) begin
          push_job.kind      = JOB_STYLE;
          push_job.width     = len_ab[4:0];
          push_job.slot_mask = {s1_shape.flags[3], s1_shape.flags[2], s1_shape.flags[1],
                                s1_shape.flags[0], s1_shape.flags[0], s1_shape.flags[0],
                                1'b1};
        end
      end
      CMD_EDGE: begin
        if (len_edge < EDGE_LIMIT) begin
          push_job.kind  = JOB_EDGE;
          push_job.width = len_edge[4:0];
          if (s1_shape.coord_a == '0) begin
            push_job.tag_bits  = VERT_TAG;
            push_job.tag_width = LINE_TAG_WIDTH;
            push_job.slot_mask = 7'b0010111;
          end else if (s1_shape.coord_b == '0) begin
            push_job.tag_bits  = HORZ_TAG;
            push_job.tag_width = LINE_TAG_WIDTH;
            push_job.slot_mask = 7'b0001111;
          end else begin
            push_job.tag_bits  = GENERAL_TAG;
            push_job.tag_width = GENERAL_TAG_WIDTH;
            push_job.slot_mask = 7'b0011111;
          end
        end
      end
      CMD_CURVE: begin
        if (len_curve < EDGE_LIMIT) begin
          push_job.kind      = JOB_CURVE;
          push_job.width     = len_curve[4:0];
          push_job.slot_mask = 7'b0111111;
        end
      end
      default: ;
    endcase
  end

  // A style change with no flags set produces nothing.
  assign push = s1_valid && !(s1_shape.command == CMD_STYLE && s1_shape.flags == '0);

endmodule

[rtl/vsrbp_queue.sv]
// Short job queue between the front and back ends.
module vsrbp_queue #(
  parameter int unsigned QueueDepth = vsrbp_pkg::DefaultQueueDepth,
  localparam int unsigned LevelWidth = $clog2(QueueDepth + 1),
  localparam int unsigned PtrWidth   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  vsrbp_pkg::job_t       push_job,
  input  logic                  pop,
  output logic                  head_valid,
  output vsrbp_pkg::job_t       head_job,
  output logic [LevelWidth-1:0] level
);
  import vsrbp_pkg::*;

  job_t                  entries [QueueDepth];
  logic [PtrWidth-1:0]   wr_ptr;
  logic [PtrWidth-1:0]   rd_ptr;
  logic [LevelWidth-1:0] level_next;

  always_comb begin
    level_next = level;
    if (push && !pop) begin
      level_next = level + LevelWidth'(1);
    end else if (pop && !push) begin
      level_next = level - LevelWidth'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      level <= level_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr + PtrWidth'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr + PtrWidth'(1);
      end
    end
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  assign head_valid = (level != '0);
  assign head_job   = entries[rd_ptr];

endmodule

[rtl/vsrbp_back.sv]
// Back end: walks the fields of the job at the head of the queue, one field per cycle.
module vsrbp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  vsrbp_pkg::job_t   head_job,
  output logic              pop,
  output logic              field_strobe,
  output vsrbp_pkg::field_t field
);
  import vsrbp_pkg::*;

  logic [2:0]           slot;
  logic [2:0]           slot_next;
  logic [SlotCount-1:0] remaining;
  logic                 is_last;
  logic [BitsWidth-1:0] raw_bits;
  logic [BitsWidth-1:0] low_mask;
  logic [4:0]           raw_width;
  logic [3:0]           nbits;

  always_comb begin
    for (int i = 0; i < SlotCount; i++) begin
      remaining[i] = head_job.slot_mask[i] && (3'(i) > slot);
    end
    slot_next = '0;
    for (int i = SlotCount - 1; i >= 0; i--) begin
      if (remaining[i]) begin
        slot_next = 3'(i);
      end
    end
  end

  assign is_last = (remaining == '0);
  assign pop     = head_valid && is_last;
  assign nbits   = 4'(head_job.width - NBITS_BIAS);

  always_comb begin
    raw_bits  = '0;
    raw_width = '0;
    case (head_job.kind)
      JOB_STYLE: begin
        case (slot)
          3'd0: begin raw_bits = BitsWidth'(head_job.flags); raw_width = FLAGS_WIDTH; end
          3'd1: begin raw_bits = BitsWidth'(head_job.width); raw_width = MOVE_BITS_WIDTH; end
          3'd2: begin raw_bits = head_job.a; raw_width = head_job.width; end
          3'd3: begin raw_bits = head_job.b; raw_width = head_job.width; end
          3'd4: begin
            raw_bits  = BitsWidth'(head_job.left_fill);
            raw_width = head_job.fill_width;
          end
          3'd5: begin
            raw_bits  = BitsWidth'(head_job.right_fill);
            raw_width = head_job.fill_width;
          end
          default: begin
            raw_bits  = BitsWidth'(head_job.line_style);
            raw_width = head_job.line_width;
          end
        endcase
      end
      JOB_EDGE: begin
        case (slot)
          3'd0: begin raw_bits = BitsWidth'(EDGE_TAG); raw_width = TAG_WIDTH; end
          3'd1: begin raw_bits = BitsWidth'(nbits); raw_width = EDGE_NBITS_WIDTH; end
          3'd2: begin
            raw_bits  = BitsWidth'(head_job.tag_bits);
            raw_width = 5'(head_job.tag_width);
          end
          3'd3: begin raw_bits = head_job.a; raw_width = head_job.width; end
          default: begin raw_bits = head_job.b; raw_width = head_job.width; end
        endcase
      end
      JOB_CURVE: begin
        case (slot)
          3'd0: begin raw_bits = BitsWidth'(CURVE_TAG); raw_width = TAG_WIDTH; end
          3'd1: begin raw_bits = BitsWidth'(nbits); raw_width = EDGE_NBITS_WIDTH; end
          3'd2: begin raw_bits = head_job.a; raw_width = head_job.width; end
          3'd3: begin raw_bits = head_job.b; raw_width = head_job.width; end
          3'd4: begin raw_bits = BitsWidth'(head_job.c); raw_width = head_job.width; end
          default: begin raw_bits = BitsWidth'(head_job.d); raw_width = head_job.width; end
        endcase
      end
      default: begin
        raw_bits  = '0;
        raw_width = '0;
      end
    endcase
  end

  // At a width of 31 the shift drops out and the mask comes out all ones.
  assign low_mask = (BitsWidth'(1) << raw_width) - BitsWidth'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      field_strobe <= 1'b0;
      slot         <= '0;
    end else begin
      field_strobe <= head_valid;
      if (head_valid) begin
        slot <= is_last ? 3'd0 : slot_next;
      end
    end
    field.field_bits  <= raw_bits & low_mask;
    field.field_width <= raw_width;
    field.last        <= is_last;
    field.error       <= (head_job.kind == JOB_ERROR);
  end

endmodule

[rtl/vector_shape_record_bit_packer.sv]
// Top level of the vector shape record bit packer: front end, job queue and back end.
//
//   channel   signals                               transfer at
//   --------  ------------------------------------  ----------------------------
//   record    start, busy, shape                    start high and busy low
//   config    cfg_valid, cfg_ready, cfg_index/data  cfg_valid and cfg_ready high
//   field     field_strobe, field                   every cycle field_strobe is high
//
// A record yields up to seven fields (a style change with no flags yields none), one per
// cycle from the back end sequencer; records follow each other without gaps.
// A record passes the front stage and the queue before its first field is registered.
// Reset clears both style counts and empties the queue; busy is low after reset.
// busy rises when the queue and the front stage together hold QueueDepth records.
// Fields cannot be held off, so the back end never stalls.
module vector_shape_record_bit_packer #(
  parameter int unsigned QueueDepth = vsrbp_pkg::DefaultQueueDepth
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  vsrbp_pkg::shape_t                   shape,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vsrbp_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [vsrbp_pkg::CountWidth-1:0]    cfg_data,
  output logic                                field_strobe,
  output vsrbp_pkg::field_t                   field
);
  import vsrbp_pkg::*;

  localparam int unsigned LevelWidth = $clog2(QueueDepth + 1);

  logic                  push;
  job_t                  push_job;
  logic                  pop;
  logic                  head_valid;
  job_t                  head_job;
  logic [LevelWidth-1:0] level;

  assign cfg_ready = 1'b1;

  vsrbp_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .shape     (shape),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .level     (level),
    .push      (push),
    .push_job  (push_job)
  );

  vsrbp_queue #(
    .QueueDepth(QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job),
    .level      (level)
  );

  vsrbp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_job     (head_job),
    .pop          (pop),
    .field_strobe (field_strobe),
    .field        (field)
  );

endmodule

[rtl/vsrbp_checker.sv]
// Port-level checks on the bit packer and the bind that attaches them.
module vsrbp_checker (
  input logic              clk,
  input logic              rst,
  input logic              busy,
  input logic              field_strobe,
  input vsrbp_pkg::field_t field
);
  import vsrbp_pkg::*;

  // Reset leaves nothing pending and nothing on the result ports.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !field_strobe && !busy)
    else $error("field strobe or busy set right after reset");

  // An error result stands alone and carries an empty field.
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    field_strobe && field.error |->
      field.last && field.field_bits == '0 && field.field_width == '0)
    else $error("error result with payload or without last");

  // No value bits above the field width.
  a_bits_fit: assert property (@(posedge clk) disable iff (rst)
    field_strobe |-> (field.field_bits >> field.field_width) == '0)
    else $error("field bits wider than field width");

  // A record opens with its flags field or its two-bit kind tag.
  a_record_head: assert property (@(posedge clk) disable iff (rst)
    field_strobe && field.last |=>
      !field_strobe || field.error || field.field_width == FLAGS_WIDTH ||
      field.field_width == TAG_WIDTH)
    else $error("record does not begin with a head field");

endmodule

bind vector_shape_record_bit_packer vsrbp_checker u_vsrbp_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .field_strobe (field_strobe),
  .field        (field)
);

[sim/shape_field_checker.sv]
// Checker for the shape record bit packer: predicts the field run of every record and compares.
module shape_field_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  vsrbp_pkg::shape_t                   shape,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [vsrbp_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [vsrbp_pkg::CountWidth-1:0]    cfg_data,
  input  logic                                field_strobe,
  input  vsrbp_pkg::field_t                   field,
  output int                                  fail_count,
  output int                                  pending
);
  import vsrbp_pkg::*;

  localparam field_t ErrorField = '{field_bits: '0, field_width: '0, last: 1'b1, error: 1'b1};

  field_t                expected_fields[$];
  logic [CountWidth-1:0] fill_styles;
  logic [CountWidth-1:0] line_styles;

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic int unsigned bit_length(input logic [31:0] v);
    int unsigned n;
    n = 0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        n = i + 1;
      end
    end
    return n;
  endfunction

  function automatic int unsigned signed_width(input logic [31:0] u);
    return bit_length(u[31] ? ~u : u) + 1;
  endfunction

  function automatic field_t make_field(input logic [63:0] value, input int unsigned w);
    field_t f;
    f.field_bits  = 31'(value & ((64'd1 << w) - 64'd1));
    f.field_width = 5'(w);
    f.last        = 1'b0;
    f.error       = 1'b0;
    return f;
  endfunction

  // Works out the field run of one record and queues it.
  task automatic predict_fields(input shape_t s);
    field_t      run[$];
    int unsigned n;
    int unsigned fill_w;
    int unsigned line_w;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    a      = s.coord_a;
    b      = s.coord_b;
    c      = s.coord_c;
    d      = s.coord_d;
    fill_w = bit_length({16'd0, fill_styles});
    line_w = bit_length({16'd0, line_styles});
    n      = 0;
    case (command_t'(s.command))
      CMD_STYLE: begin
        if (s.flags == '0) begin
          return;
        end
        if (s.flags[0]) begin
          n = (signed_width(a) > signed_width(b)) ? signed_width(a) : signed_width(b);
          if (n >= MOVE_LIMIT) begin
            expected_fields.push_back(ErrorField);
            return;
          end
        end
        run.push_back(make_field(s.flags, FLAGS_WIDTH));
        if (s.flags[0]) begin
          run.push_back(make_field(n, MOVE_BITS_WIDTH));
          run.push_back(make_field(a, n));
          run.push_back(make_field(b, n));
        end
        if (s.flags[1]) begin
          run.push_back(make_field(s.left_fill, fill_w));
        end
        if (s.flags[2]) begin
          run.push_back(make_field(s.right_fill, fill_w));
        end
        if (s.flags[3]) begin
          run.push_back(make_field(s.line_style, line_w));
        end
      end
      CMD_EDGE: begin
        if (a == '0) begin
          n = signed_width(b);
        end else if (b == '0) begin
          n = signed_width(a);
        end else begin
          n = (signed_width(a) > signed_width(b)) ? signed_width(a) : signed_width(b);
        end
        if (n < MIN_EDGE_WIDTH) begin
          n = MIN_EDGE_WIDTH;
        end
        if (n >= EDGE_LIMIT) begin
          expected_fields.push_back(ErrorField);
          return;
        end
        run.push_back(make_field(EDGE_TAG, TAG_WIDTH));
        run.push_back(make_field(n - NBITS_BIAS, EDGE_NBITS_WIDTH));
        if (a == '0) begin
          run.push_back(make_field(VERT_TAG, LINE_TAG_WIDTH));
          run.push_back(make_field(b, n));
        end else if (b == '0) begin
          run.push_back(make_field(HORZ_TAG, LINE_TAG_WIDTH));
          run.push_back(make_field(a, n));
        end else begin
          run.push_back(make_field(GENERAL_TAG, GENERAL_TAG_WIDTH));
          run.push_back(make_field(a, n));
          run.push_back(make_field(b, n));
        end
      end
      CMD_CURVE: begin
        n = signed_width(a);
        if (signed_width(b) > n) n = signed_width(b);
        if (signed_width(c) > n) n = signed_width(c);
        if (signed_width(d) > n) n = signed_width(d);
        if (n < MIN_EDGE_WIDTH) begin
          n = MIN_EDGE_WIDTH;
        end
        if (n >= EDGE_LIMIT) begin
          expected_fields.push_back(ErrorField);
          return;
        end
        run.push_back(make_field(CURVE_TAG, TAG_WIDTH));
        run.push_back(make_field(n - NBITS_BIAS, EDGE_NBITS_WIDTH));
        run.push_back(make_field(a, n));
        run.push_back(make_field(b, n));
        run.push_back(make_field(c, n));
        run.push_back(make_field(d, n));
      end
      default: begin
        expected_fields.push_back(ErrorField);
        return;
      end
    endcase
    run[run.size() - 1].last = 1'b1;
    foreach (run[i]) begin
      expected_fields.push_back(run[i]);
    end
  endtask

  task automatic check_field(input field_t got);
    field_t want;
    if (expected_fields.size() == 0) begin
      report_mismatch($sformatf("field %h arrived with no field expected", got));
      return;
    end
    want = expected_fields.pop_front();
    if (got.field_bits !== want.field_bits) begin
      report_mismatch($sformatf("field_bits %h, expected %h", got.field_bits, want.field_bits));
    end
    if (got.field_width !== want.field_width) begin
      report_mismatch($sformatf("field_width %0d, expected %0d",
                                got.field_width, want.field_width));
    end
    if (got.last !== want.last) begin
      report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
    end
    if (got.error !== want.error) begin
      report_mismatch($sformatf("error %b, expected %b", got.error, want.error));
    end
  endtask

  // A field leaves only after its record has passed the front stage and queue, so checking
  // before predicting at the same edge never pairs a field with the record just taken in.
  always @(posedge clk) begin
    if (rst) begin
      expected_fields.delete();
      fill_styles = '0;
      line_styles = '0;
    end else begin
      if (field_strobe) begin
        check_field(field);
      end
      if (start && !busy) begin
        predict_fields(shape);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FILL_COUNT: fill_styles = cfg_data;
          CFG_LINE_COUNT: line_styles = cfg_data;
          default: ;
        endcase
      end
    end
    pending <= expected_fields.size();
  end

endmodule

[sim/vector_shape_record_bit_packer_tb.sv]
// Testbench top for the shape record bit packer: stimulus, style count settings and verdict.
module vector_shape_record_bit_packer_tb;
  import vsrbp_pkg::*;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  shape_t                   shape;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CountWidth-1:0]    cfg_data;
  logic                     field_strobe;
  field_t                   field;
  int                       fail_count;
  int                       pending;

  vector_shape_record_bit_packer dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .shape       (shape),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .field_strobe(field_strobe),
    .field       (field)
  );

  shape_field_checker checker_inst (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .shape       (shape),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .field_strobe(field_strobe),
    .field       (field),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #2400000;
    $display("** vector_shape_record_bit_packer: FAILED **");
    $finish;
  end

  function automatic shape_t make_shape(input command_t cmd, input logic [5:0] flags,
                                        input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c, input logic [31:0] d,
                                        input logic [15:0] lf, input logic [15:0] rf,
                                        input logic [15:0] ls);
    shape_t s;
    s.command    = cmd;
    s.flags      = flags;
    s.coord_a    = a;
    s.coord_b    = b;
    s.coord_c    = c;
    s.coord_d    = d;
    s.left_fill  = lf;
    s.right_fill = rf;
    s.line_style = ls;
    return s;
  endfunction

  // Random value that fits a random signed width up to max_w, zero now and then.
  function automatic logic [31:0] random_coord(input int unsigned max_w);
    int unsigned w;
    logic [31:0] v;
    if ($urandom_range(9) == 0) begin
      return '0;
    end
    w = $urandom_range(max_w, 1);
    v = $urandom;
    return 32'($signed(v << (32 - w)) >>> (32 - w));
  endfunction

  function automatic shape_t random_record();
    shape_t      s;
    int unsigned pick;
    int unsigned max_w;
    pick = $urandom_range(99);
    if (pick < 35) begin
      s.command = CMD_STYLE;
      max_w     = ($urandom_range(9) == 0) ? 32 : 31;
    end else if (pick < 65) begin
      s.command = CMD_EDGE;
      max_w     = ($urandom_range(9) == 0) ? 32 : 17;
    end else if (pick < 92) begin
      s.command = CMD_CURVE;
      max_w     = ($urandom_range(9) == 0) ? 32 : 17;
    end else begin
      s.command = CMD_UNKNOWN;
      max_w     = 32;
    end
    s.flags      = ($urandom_range(19) == 0) ? 6'd0 : 6'($urandom_range(63));
    s.coord_a    = random_coord(max_w);
    s.coord_b    = random_coord(max_w);
    s.coord_c    = random_coord(max_w);
    s.coord_d    = random_coord(max_w);
    s.left_fill  = 16'($urandom);
    s.right_fill = 16'($urandom);
    s.line_style = 16'($urandom);
    // Steer edges toward the vertical and horizontal forms.
    if (s.command == CMD_EDGE) begin
      pick = $urandom_range(9);
      if (pick < 2) begin
        s.coord_a = '0;
      end else if (pick < 4) begin
        s.coord_b = '0;
      end
    end
    return s;
  endfunction

  task automatic send_record(input shape_t s, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      shape <= random_record();
      @(posedge clk);
    end
    start <= 1'b1;
    shape <= s;
    do @(posedge clk); while (busy);
  endtask

  // Stop sending and wait until every expected field has come out; records that give
  // no field may still be in the pipe, so allow some extra cycles before a write.
  task automatic drain_records();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic write_count(input logic [CfgIndexWidth-1:0] idx,
                             input logic [CountWidth-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned count, input int unsigned idle_pct);
    for (int unsigned i = 0; i < count; i++) begin
      send_record(random_record(), idle_pct);
    end
  endtask

  initial begin
    shape_t opening[$];
    shape_t wide_index[$];

    rst       = 1'b1;
    start     = 1'b0;
    shape     = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_FILL_COUNT;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Both style counts are still zero here, so every index goes out with no bits.
    opening.push_back(make_shape(CMD_STYLE, 6'h00, 32'd5, 32'd7, 0, 0, 16'hFFFF, 0, 0));
    opening.push_back(make_shape(CMD_STYLE, 6'h3F, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    opening.push_back(make_shape(CMD_STYLE, 6'h01, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0));
    opening.push_back(make_shape(CMD_STYLE, 6'h01, 0, 32'h8000_0000, 0, 0, 0, 0, 0));
    opening.push_back(make_shape(CMD_STYLE, 6'h0F, 32'h3FFF_FFFF, 32'hC000_0000, 0, 0,
                                 16'h1234, 16'h5678, 16'h9ABC));
    opening.push_back(make_shape(CMD_STYLE, 6'h3E, 32'hFFFF_FFFF, 0, 0, 0, 1, 2, 3));
    opening.push_back(make_shape(CMD_EDGE, 6'h3F, 0, 0, 0, 0, 0, 0, 0));
    opening.push_back(make_shape(CMD_EDGE, 6'h00, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
    opening.push_back(make_shape(CMD_EDGE, 6'h00, 32'd5, 0, 0, 0, 0, 0, 0));
    opening.push_back(make_shape(CMD_EDGE, 6'h00, 32'd65535, -32'sd65536, 0, 0, 0, 0, 0));
    opening.push_back(make_shape(CMD_EDGE, 6'h00, 32'd65536, 32'd1, 0, 0, 0, 0, 0));
    opening.push_back(make_shape(CMD_EDGE, 6'h00, 0, -32'sd131072, 0, 0, 0, 0, 0));
    opening.push_back(make_shape(CMD_EDGE, 6'h00, -32'sd131072, 0, 0, 0, 0, 0, 0));
    opening.push_back(make_shape(CMD_CURVE, 6'h00, 0, 0, 0, 0, 0, 0, 0));
    opening.push_back(make_shape(CMD_CURVE, 6'h00, -32'sd65536, 32'd65535, 32'd1,
                                 32'hFFFF_FFFF, 0, 0, 0));
    opening.push_back(make_shape(CMD_CURVE, 6'h00, 1, 1, 32'h8000_0000, 1, 0, 0, 0));
    opening.push_back(make_shape(CMD_UNKNOWN, 6'h0F, 32'd3, 32'd4, 32'd5, 32'd6, 1, 2, 3));
    opening.push_back(make_shape(CMD_UNKNOWN, 6'h00, 0, 0, 0, 0, 0, 0, 0));
    foreach (opening[i]) begin
      send_record(opening[i], 30);
    end
    drain_records();

    // A line count of one keeps only the lowest bit of the line index.
    write_count(CFG_FILL_COUNT, 16'hFFFF);
    write_count(CFG_LINE_COUNT, 16'd1);
    wide_index.push_back(make_shape(CMD_STYLE, 6'h0E, 0, 0, 0, 0,
                                    16'hFFFF, 16'hABCD, 16'hFFFF));
    wide_index.push_back(make_shape(CMD_STYLE, 6'h0F, 32'hFFFF_FFFF, 32'd1, 0, 0,
                                    16'd0, 16'h1234, 16'd2));
    wide_index.push_back(make_shape(CMD_STYLE, 6'h30, 32'd9, 32'd9, 0, 0, 0, 0, 0));
    foreach (wide_index[i]) begin
      send_record(wide_index[i], 30);
    end
    drain_records();

    write_count(CFG_FILL_COUNT, 16'($urandom_range(300, 1)));
    write_count(CFG_LINE_COUNT, 16'($urandom_range(20, 1)));
    random_phase(80, 30);
    drain_records();

    write_count(CFG_FILL_COUNT, 16'd1);
    write_count(CFG_LINE_COUNT, 16'hFFFF);
    random_phase(85, 65);
    drain_records();

    write_count(CFG_FILL_COUNT, 16'd0);
    write_count(CFG_LINE_COUNT, 16'($urandom));
    random_phase(85, 0);
    drain_records();

    if (fail_count == 0) begin
      $display("** vector_shape_record_bit_packer: PASSED **");
    end else begin
      $display("** vector_shape_record_bit_packer: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/vsrbp_pkg.sv
rtl/vsrbp_front.sv
rtl/vsrbp_queue.sv
rtl/vsrbp_back.sv
rtl/vector_shape_record_bit_packer.sv
rtl/vsrbp_checker.sv
sim/shape_field_checker.sv
sim/vector_shape_record_bit_packer_tb.sv
